// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_PROP(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("%m: check failed");

// Check a property on every clock edge, reset included.
`define CHK_PROP_ALL(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("%m: check failed");

`endif

// ===== hdl/utf8d_pkg.sv =====
// Types and constants for the UTF-8 BMP decoder.
// Used by utf8d_step and utf8_bmp_decoder_core; depends on nothing.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic [7:0] ASCII_LIM = 8'h80;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD_OVL  = 8'hE0;
  localparam logic [7:0] LEAD_SUR  = 8'hED;
  localparam logic [7:0] MID_SPLIT = 8'hA0;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  typedef struct packed {
    logic [1:0] pend;
    logic [7:0] lead;
    logic [7:0] mid;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_point;
    logic        malformed;
  } dec_result_t;

endpackage

// ===== hdl/utf8d_step.sv =====
// Next-state and result logic for one byte of the UTF-8 BMP decoder.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  in_byte,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic        bad3;
  logic        bad2;
  logic [15:0] cp3;
  logic [15:0] cp2;

  assign bad3 = (cur.mid[7:6] != CONT_TAG) || (in_byte[7:6] != CONT_TAG) ||
                ((cur.lead == LEAD_OVL) && (cur.mid < MID_SPLIT)) ||
                ((cur.lead == LEAD_SUR) && (cur.mid >= MID_SPLIT));
  assign bad2 = (in_byte[7:6] != CONT_TAG);
  assign cp3  = {cur.lead[3:0], cur.mid[5:0], in_byte[5:0]};
  assign cp2  = {5'd0, cur.lead[4:0], in_byte[5:0]};

  always_comb begin
    nxt = cur;
    res = '0;
    case (cur.pend)
      PEND_NONE: begin
        if (in_byte < ASCII_LIM) begin
          res.emit       = 1'b1;
          res.code_point = {8'd0, in_byte};
        end else if ((in_byte >= LEAD2_LO) && (in_byte <= LEAD2_HI)) begin
          nxt.lead = in_byte;
          nxt.pend = PEND_ONE;
        end else if ((in_byte >= LEAD3_LO) && (in_byte <= LEAD3_HI)) begin
          nxt.lead = in_byte;
          nxt.pend = PEND_TWO;
        end else begin
          res.emit      = 1'b1;
          res.malformed = 1'b1;
        end
      end
      PEND_TWO: begin
        nxt.mid  = in_byte;
        nxt.pend = PEND_ONE;
      end
      default: begin
        nxt.pend = PEND_NONE;
        res.emit = 1'b1;
        if (cur.lead >= LEAD3_LO) begin
          res.malformed  = bad3;
          res.code_point = bad3 ? 16'd0 : cp3;
        end else begin
          res.malformed  = bad2;
          res.code_point = bad2 ? 16'd0 : cp2;
        end
      end
    endcase
  end

endmodule

// ===== hdl/utf8_bmp_decoder_core.sv =====
// UTF-8 decoder for the Basic Multilingual Plane: a byte is taken in every cycle in
// which the input register is empty or the result register is free or being drained,
// so bytes flow at one per cycle unless the output stalls, through the input register,
// the single decode step and the result register; the result register takes each word
// from the step. Bytes that open or continue a sequence give no word; one- to three-byte
// forms yield a codepoint, anything else a malformed word with codepoint zero.
// Depends on utf8d_pkg and utf8d_step.
`timescale 1ns / 1ps

module utf8_bmp_decoder_core
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_point,
  output logic        malformed
);

  logic        byte_vld;
  logic [7:0]  byte_q;
  logic        adv;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t res;

  assign adv      = byte_vld && (!out_valid || !out_stall);
  assign in_stall = byte_vld && !adv;

  utf8d_step u_step (
    .cur     (state),
    .in_byte (byte_q),
    .nxt     (state_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!in_stall) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      code_point <= res.code_point;
      malformed  <= res.malformed;
    end
  end

endmodule

// ===== hdl/utf8d_checker.sv =====
// Port-level checks for utf8_bmp_decoder_core, bound to every instance.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] code_point,
  input logic        malformed
);

  logic [16:0] out_word;

  assign out_word = {code_point, malformed};

  `CHK_PROP(bad_word_zero, clk, rst, (out_valid && malformed) |-> (code_point == 16'd0))
  `CHK_PROP(held_word_stable, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
  `CHK_PROP(in_word_held, clk, rst, (in_valid && in_stall) |=> (in_valid && $stable(in_byte)))
  `CHK_PROP(no_stall_when_drained, clk, rst, (!out_stall) |-> (!in_stall))
  `CHK_PROP_ALL(reset_clears_out, clk, rst |=> !out_valid)

endmodule

bind utf8_bmp_decoder_core utf8d_checker u_utf8d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .code_point (code_point),
  .malformed  (malformed)
);

// ===== test/tb_top.sv =====
// Testbench for utf8_bmp_decoder_core: random byte streams with bursty input and stalled output.
// Predicts each decoded word in-line and checks codepoint and malformed flag in order.
// Depends on utf8d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  typedef struct packed {
    logic [15:0] code_point;
    logic        malformed;
  } cp_word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  localparam int STIM_BYTES = 1724;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_point;
  logic        malformed;

  logic [7:0]  byte_q[$];
  cp_word_t    cp_expect_q[$];
  int          mismatch_count = 0;

  logic [1:0]  seq_pend = PEND_NONE;
  logic [7:0]  seq_lead = 8'h00;
  logic [7:0]  seq_mid = 8'h00;

  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  rx_mode_t    stall_mode = RX_FREE;

  utf8_bmp_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .malformed  (malformed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void decode_utf8_byte(input logic [7:0] b);
    logic        done;
    logic        bad;
    logic [15:0] cp;
    cp_word_t    w;
    done = 1'b0;
    bad  = 1'b0;
    cp   = 16'h0000;
    if (seq_pend == PEND_NONE) begin
      if (b < ASCII_LIM) begin
        done = 1'b1;
        cp   = {8'h00, b};
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        seq_lead = b;
        seq_pend = PEND_ONE;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        seq_lead = b;
        seq_pend = PEND_TWO;
      end else begin
        done = 1'b1;
        bad  = 1'b1;
      end
    end else if (seq_pend == PEND_TWO) begin
      seq_mid  = b;
      seq_pend = PEND_ONE;
    end else begin
      // last byte of the open sequence; a count of three finishes here too
      seq_pend = PEND_NONE;
      done     = 1'b1;
      if (seq_lead >= LEAD3_LO) begin
        bad = (seq_mid[7:6] != CONT_TAG) || (b[7:6] != CONT_TAG) ||
              (seq_lead == LEAD_OVL && seq_mid < MID_SPLIT) ||
              (seq_lead == LEAD_SUR && seq_mid >= MID_SPLIT);
        cp  = {seq_lead[3:0], seq_mid[5:0], b[5:0]};
      end else begin
        bad = (b[7:6] != CONT_TAG);
        cp  = {5'b00000, seq_lead[4:0], b[5:0]};
      end
    end
    if (done) begin
      w.code_point = bad ? 16'h0000 : cp;
      w.malformed  = bad;
      cp_expect_q.push_back(w);
    end
  endfunction

  initial begin : fill_bytes
    logic [7:0] lead;
    logic [7:0] mid;
    int         kind;
    byte_q = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFF,
               8'hC2, 8'h80, 8'hDF, 8'hBF,
               8'hE0, 8'h9F, 8'hBF,
               8'hED, 8'hA0, 8'h80,
               8'hEF, 8'hBF, 8'hBF,
               8'hC3, 8'h41,
               8'hE1, 8'h00, 8'h80,
               8'hF0};
    while (byte_q.size() < STIM_BYTES) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          byte_q.push_back(8'($urandom_range(0, 8'h7F)));
        end
        3, 4: begin
          byte_q.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
          byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        5, 6: begin
          lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
          if (lead == LEAD_OVL) begin
            mid = 8'($urandom_range(MID_SPLIT, 8'hBF));
          end else if (lead == LEAD_SUR) begin
            mid = 8'($urandom_range(8'h80, 8'h9F));
          end else begin
            mid = 8'($urandom_range(8'h80, 8'hBF));
          end
          byte_q.push_back(lead);
          byte_q.push_back(mid);
          byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        7: begin
          byte_q.push_back($urandom_range(0, 1) ? LEAD_OVL : LEAD_SUR);
          byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
          byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        8: begin
          if ($urandom_range(0, 1)) begin
            byte_q.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
          end else begin
            byte_q.push_back(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
            byte_q.push_back(8'($urandom_range(0, 255)));
          end
          byte_q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          byte_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid <= 1'b1;
        in_byte  <= byte_q.pop_front();
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(10, 80);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_stall <= ((stall_left % 8) < 5);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      decode_utf8_byte(in_byte);
    end
  end

  always @(posedge clk) begin : check_words
    cp_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (cp_expect_q.size() == 0) begin
        $error("unexpected word: code_point %h malformed %b", code_point, malformed);
        mismatch_count++;
      end else begin
        w = cp_expect_q.pop_front();
        if (code_point !== w.code_point) begin
          $error("code_point: expected %h, got %h", w.code_point, code_point);
          mismatch_count++;
        end
        if (malformed !== w.malformed) begin
          $error("malformed: expected %b, got %b", w.malformed, malformed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    wait (!rst);
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/utf8d_pkg.sv
hdl/utf8d_step.sv
hdl/utf8_bmp_decoder_core.sv
hdl/utf8d_checker.sv
test/tb_top.sv
